// ===== rtl/rvn_pkg.sv =====
package rvn_pkg;

   localparam int WORD_W      = 32;
   localparam int UNIT_BITS   = 30;
   localparam int LANES       = 3;
   localparam int SQ_W        = 2 * WORD_W;
   localparam int LEN_W       = WORD_W;
   localparam int EPS_W       = 31;
   localparam int DOT_W       = 2 * WORD_W;
   localparam int PROD_W      = DOT_W + WORD_W;
   localparam int MAG_W       = 61;
   localparam int QUOT_W      = UNIT_BITS + 1;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

   // pipeline stage map (index = register stage holding the value)
   localparam int SQRT_STAGES = LEN_W;
   localparam int DIV_STAGES  = QUOT_W;
   localparam int COMP_STAGES = 4;
   localparam int ST_SUM      = 2;
   localparam int ST_LEN      = ST_SUM + SQRT_STAGES;
   localparam int ST_QUOT     = ST_LEN + DIV_STAGES;
   localparam int ST_PROD     = ST_QUOT + 1;
   localparam int ST_TERM     = ST_PROD + 1;
   localparam int ST_DOT      = ST_TERM + 1;
   localparam int ST_LAST     = ST_DOT + COMP_STAGES;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type [LANES-1:0] vec;
      word_type [LANES-1:0] nrm;
      word_type [LANES-1:0] unit;
      logic                 degen;
   } side_type;

   typedef struct packed {
      word_type [LANES-1:0] refl;
      logic                 degen;
      logic                 sat;
   } rsl_type;

endpackage

// ===== rtl/rvn_sqrt.sv =====
module rvn_sqrt
   import rvn_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [SQ_W-1:0]  sq_sum,
   output logic [LEN_W-1:0] len
);

   logic [SQ_W-1:0] rem_ff  [SQRT_STAGES];
   logic [SQ_W-1:0] root_ff [SQRT_STAGES];

   genvar s;
   generate
      for (s = 0; s < SQRT_STAGES; s++) begin : g_step
         localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * s);
         logic [SQ_W-1:0] rem_cur, root_cur, trial, rem_in, root_in;

         if (s == 0) begin : g_first
            assign rem_cur  = sq_sum;
            assign root_cur = '0;
         end else begin : g_next
            assign rem_cur  = rem_ff[s-1];
            assign root_cur = root_ff[s-1];
         end

         always_comb begin
            trial = root_cur + BIT;
            if (rem_cur >= trial) begin
               rem_in  = rem_cur - trial;
               root_in = (root_cur >> 1) + BIT;
            end else begin
               rem_in  = rem_cur;
               root_in = root_cur >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s]  <= rem_in;
               root_ff[s] <= root_in;
            end
         end
      end
   endgenerate

   assign len = root_ff[SQRT_STAGES-1][LEN_W-1:0];

endmodule

// ===== rtl/rvn_div.sv =====
module rvn_div
   import rvn_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [WORD_W-1:0] num_mag,
   input  logic [LEN_W-1:0]  den,
   output logic [QUOT_W-1:0] quot
);

   localparam int NUM_W = WORD_W + UNIT_BITS;

   logic [NUM_W-1:0]  num_full;
   logic [LEN_W-1:0]  rem_ff [DIV_STAGES];
   logic [QUOT_W-1:0] lo_ff  [DIV_STAGES];
   logic [QUOT_W-1:0] q_ff   [DIV_STAGES];
   logic [LEN_W-1:0]  den_ff [DIV_STAGES];

   assign num_full = {num_mag, {UNIT_BITS{1'b0}}};

   genvar s;
   generate
      for (s = 0; s < DIV_STAGES; s++) begin : g_step
         logic [LEN_W-1:0]  rem_cur, den_cur, rem_in;
         logic [QUOT_W-1:0] lo_cur, q_cur, lo_in, q_in;
         logic [LEN_W:0]    trial;

         if (s == 0) begin : g_first
            assign rem_cur = LEN_W'(num_full[NUM_W-1:QUOT_W]);
            assign lo_cur  = num_full[QUOT_W-1:0];
            assign q_cur   = '0;
            assign den_cur = den;
         end else begin : g_next
            assign rem_cur = rem_ff[s-1];
            assign lo_cur  = lo_ff[s-1];
            assign q_cur   = q_ff[s-1];
            assign den_cur = den_ff[s-1];
         end

         always_comb begin
            trial = {rem_cur, lo_cur[QUOT_W-1]};
            lo_in = lo_cur << 1;
            if (trial >= {1'b0, den_cur}) begin
               rem_in = LEN_W'(trial - {1'b0, den_cur});
               q_in   = {q_cur[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in = trial[LEN_W-1:0];
               q_in   = {q_cur[QUOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               lo_ff[s]  <= lo_in;
               q_ff[s]   <= q_in;
               den_ff[s] <= den_cur;
            end
         end
      end
   endgenerate

   assign quot = q_ff[DIV_STAGES-1];

endmodule

// ===== rtl/rvn_comp.sv =====
module rvn_comp
   import rvn_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [DOT_W-1:0]  dot,
   input  logic        [WORD_W-1:0] unit,
   input  logic        [WORD_W-1:0] vec,
   input  logic                     degen,
   output logic        [WORD_W-1:0] refl,
   output logic                     sat
);

   localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << (MAG_W - 1);

   // stage 1: split 2*|d| * |m| into two 32x32 products
   logic [DOT_W-1:0]  dot_mag, dbl;
   logic [WORD_W-1:0] unit_mag;
   logic [DOT_W-1:0]  lo_ff, hi_ff;
   logic              neg1_ff, dgn1_ff;
   logic [WORD_W-1:0] vec1_ff;

   always_comb begin
      dot_mag  = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
      dbl      = dot_mag << 1;
      unit_mag = unit[WORD_W-1] ? (~unit + WORD_W'(1)) : unit;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= DOT_W'(dbl[WORD_W-1:0]) * DOT_W'(unit_mag);
         hi_ff   <= DOT_W'(dbl[DOT_W-1:WORD_W]) * DOT_W'(unit_mag);
         neg1_ff <= dot[DOT_W-1] ^ unit[WORD_W-1];
         dgn1_ff <= degen;
         vec1_ff <= vec;
      end
   end

   // stage 2: recombine
   logic [PROD_W-1:0] prod_ff;
   logic              neg2_ff, dgn2_ff;
   logic [WORD_W-1:0] vec2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {hi_ff, {WORD_W{1'b0}}} + PROD_W'(lo_ff);
         neg2_ff <= neg1_ff;
         dgn2_ff <= dgn1_ff;
         vec2_ff <= vec1_ff;
      end
   end

   // stage 3: drop fraction bits, clamp magnitude
   logic [PROD_W-1:0] shifted;
   logic [MAG_W-1:0]  mag_in, mag_ff;
   logic              neg3_ff;
   logic [WORD_W-1:0] vec3_ff;

   always_comb begin
      shifted = dgn2_ff ? (prod_ff >> FRAC_BITS) : (prod_ff >> UNIT_BITS);
      if ((|shifted[PROD_W-1:MAG_W]) ||
          (shifted[MAG_W-1] && (|shifted[MAG_W-2:0])))
         mag_in = MAG_LIMIT;
      else
         mag_in = shifted[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         neg3_ff <= neg2_ff;
         vec3_ff <= vec2_ff;
      end
   end

   // stage 4: subtract v and saturate
   logic signed [DOT_W-1:0] t_val, r_val;
   logic [WORD_W-1:0]       refl_in, refl_ff;
   logic                    sat_in, sat_ff;

   always_comb begin
      t_val = neg3_ff ? -$signed(DOT_W'(mag_ff)) : $signed(DOT_W'(mag_ff));
      r_val = t_val - $signed({{(DOT_W-WORD_W){vec3_ff[WORD_W-1]}}, vec3_ff});
      if (r_val > $signed(DOT_W'(32'h7FFF_FFFF))) begin
         refl_in = 32'h7FFF_FFFF;
         sat_in  = 1'b1;
      end else if (r_val < -$signed(DOT_W'(33'h1_0000_0000) >>> 1)) begin
         refl_in = 32'h8000_0000;
         sat_in  = 1'b1;
      end else begin
         refl_in = r_val[WORD_W-1:0];
         sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff <= refl_in;
         sat_ff  <= sat_in;
      end
   end

   assign refl = refl_ff;
   assign sat  = sat_ff;

endmodule

// ===== rtl/vector_reflect_about_normal_unit.sv =====
// Reflects a vector v about a mirror normal n, both signed Q16.16, giving
// 2*(v.u)*u - v with u = n/|n|, each component saturated to 32 bits. The
// length |n| comes from a 32-stage pipelined integer square root, and each
// normal component is scaled to a 30-bit-fraction unit value by a 31-stage
// pipelined restoring divider (one per lane). If |n| <= length_epsilon the
// normal is used as given and degenerate_normal is set. The unit takes one
// item every cycle while req_stall is low; its latency to the result register
// is set mostly by the square root and divider pipelines. A two-deep
// output (result register plus skid register) lets the pipe keep moving
// while a result waits; req_stall rises only once the skid register holds
// an item. The epsilon register is write-only through the csr channel,
// always ready, and must only be written while the unit is empty.
module vector_reflect_about_normal_unit
   import rvn_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_vec_x,
   input  logic signed [31:0]      req_vec_y,
   input  logic signed [31:0]      req_vec_z,
   input  logic signed [31:0]      req_normal_x,
   input  logic signed [31:0]      req_normal_y,
   input  logic signed [31:0]      req_normal_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_refl_x,
   output logic signed [31:0]      rsp_refl_y,
   output logic signed [31:0]      rsp_refl_z,
   output logic                    rsp_degenerate_normal,
   output logic                    rsp_saturated,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [EPS_W-1:0]        csr_length_epsilon
);

   // config
   logic [EPS_W-1:0] eps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_valid) begin
         eps_ff <= csr_length_epsilon;
      end
   end

   // whole pipe advances together; only the skid register can hold it
   logic pipe_en;
   logic skid_vld_ff;
   logic vld_ff [ST_LAST+1];

   assign pipe_en   = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ST_LAST; k++) vld_ff[k] <= 1'b0;
      end else if (pipe_en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= ST_LAST; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // side data: v, n, later the degen flag and scaled normal ride along
   side_type         side_ff [ST_DOT+1];
   side_type         side_in [ST_DOT+1];
   logic [LEN_W-1:0] len;
   word_type [LANES-1:0] unit_cur;
   logic [QUOT_W-1:0] quot [LANES];

   always_comb begin
      side_in[0]       = side_ff[0];
      side_in[0].vec   = {req_vec_z, req_vec_y, req_vec_x};
      side_in[0].nrm   = {req_normal_z, req_normal_y, req_normal_x};
      side_in[0].unit  = '0;
      side_in[0].degen = 1'b0;
      for (int k = 1; k <= ST_DOT; k++) begin
         side_in[k] = side_ff[k-1];
         if (k == ST_LEN + 1) side_in[k].degen = (len <= LEN_W'(eps_ff));
         if (k == ST_PROD)    side_in[k].unit  = unit_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k <= ST_DOT; k++) side_ff[k] <= side_in[k];
      end
   end

   // lanes: square, divide, dot product term
   logic [SQ_W-1:0]         sq_ff   [LANES];
   logic signed [DOT_W-1:0] prod_ff [LANES];
   logic signed [DOT_W-1:0] term_ff [LANES];
   logic [WORD_W-1:0]       refl    [LANES];
   logic                    lane_sat [LANES];
   logic signed [DOT_W-1:0] dot_ff;

   genvar i;
   generate
      for (i = 0; i < LANES; i++) begin : g_lane
         logic [WORD_W-1:0]       n0, n_len, n_q, v_q, nmag0, nmag_len;
         logic [WORD_W-1:0]       q_ext;
         logic signed [DOT_W-1:0] p_mag, p_sh;

         assign n0       = side_ff[0].nrm[i];
         assign n_len    = side_ff[ST_LEN].nrm[i];
         assign n_q      = side_ff[ST_QUOT].nrm[i];
         assign v_q      = side_ff[ST_QUOT].vec[i];
         assign nmag0    = n0[WORD_W-1] ? (~n0 + WORD_W'(1)) : n0;
         assign nmag_len = n_len[WORD_W-1] ? (~n_len + WORD_W'(1)) : n_len;
         assign q_ext    = WORD_W'(quot[i]);

         always_comb begin
            if (side_ff[ST_QUOT].degen)
               unit_cur[i] = n_q;
            else if (n_q[WORD_W-1])
               unit_cur[i] = ~q_ext + WORD_W'(1);
            else
               unit_cur[i] = q_ext;
         end

         // truncating shift toward zero
         always_comb begin
            p_mag = prod_ff[i][DOT_W-1] ? -prod_ff[i] : prod_ff[i];
            p_sh  = side_ff[ST_PROD].degen ? (p_mag >>> FRAC_BITS)
                                           : (p_mag >>> UNIT_BITS);
         end

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               sq_ff[i]   <= SQ_W'(nmag0) * SQ_W'(nmag0);
               prod_ff[i] <= $signed({{WORD_W{v_q[WORD_W-1]}}, v_q}) *
                             $signed({{WORD_W{unit_cur[i][WORD_W-1]}}, unit_cur[i]});
               term_ff[i] <= prod_ff[i][DOT_W-1] ? -p_sh : p_sh;
            end
         end

         rvn_div u_div (
            .clock   (clock),
            .en      (pipe_en),
            .num_mag (nmag_len),
            .den     (len),
            .quot    (quot[i])
         );

         rvn_comp #(.FRAC_BITS(FRAC_BITS)) u_comp (
            .clock (clock),
            .en    (pipe_en),
            .dot   (dot_ff),
            .unit  (side_ff[ST_DOT].unit[i]),
            .vec   (side_ff[ST_DOT].vec[i]),
            .degen (side_ff[ST_DOT].degen),
            .refl  (refl[i]),
            .sat   (lane_sat[i])
         );
      end
   endgenerate

   // merge: |n|^2 and the dot product
   logic [SQ_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         dot_ff <= term_ff[0] + term_ff[1] + term_ff[2];
      end
   end

   rvn_sqrt u_sqrt (
      .clock  (clock),
      .en     (pipe_en),
      .sq_sum (sum_ff),
      .len    (len)
   );

   // degen flag follows the component lanes
   logic dgn_tail_ff [COMP_STAGES];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dgn_tail_ff[0] <= side_ff[ST_DOT].degen;
         for (int k = 1; k < COMP_STAGES; k++) dgn_tail_ff[k] <= dgn_tail_ff[k-1];
      end
   end

   // tail item, flags merged across lanes
   rsl_type tail;

   always_comb begin
      tail.refl  = {refl[2], refl[1], refl[0]};
      tail.degen = dgn_tail_ff[COMP_STAGES-1];
      tail.sat   = lane_sat[0] | lane_sat[1] | lane_sat[2];
   end

   // result register plus skid register
   rsl_type out_ff, skid_ff;
   logic    rsp_valid_ff;
   logic    out_free;
   logic    tail_vld;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign tail_vld = vld_ff[ST_LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
            skid_vld_ff  <= 1'b0;
         end
      end else if (tail_vld) begin
         if (out_free) rsp_valid_ff <= 1'b1;
         else          skid_vld_ff  <= 1'b1;
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) out_ff <= skid_ff;
      end else if (tail_vld) begin
         if (out_free) out_ff  <= tail;
         else          skid_ff <= tail;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_refl_x            = $signed(out_ff.refl[0]);
   assign rsp_refl_y            = $signed(out_ff.refl[1]);
   assign rsp_refl_z            = $signed(out_ff.refl[2]);
   assign rsp_degenerate_normal = out_ff.degen;
   assign rsp_saturated         = out_ff.sat;

endmodule
